// ----- hw/rtl/cia_pkg.sv -----
`timescale 1ns / 1ps
package cia_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    op_e  op;
    logic neg;
    logic ovf;
  } ctl_t;

endpackage

// ----- hw/rtl/cia_if.sv -----
`timescale 1ns / 1ps
interface cia_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface cia_rsp_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         error_flag;

  modport source (output valid, result_value, error_flag, input ready);
  modport sink (input valid, result_value, error_flag, output ready);
endinterface

// ----- hw/rtl/cia_front.sv -----
`timescale 1ns / 1ps
module cia_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [1:0]            req_type_i,
  input  logic [DATA_WIDTH-1:0] operand_a_i,
  input  logic [DATA_WIDTH-1:0] operand_b_i,
  output cia_pkg::ctl_t         ctl_o,
  output logic [DATA_WIDTH-1:0] mag_a_o,
  output logic [DATA_WIDTH-1:0] mag_b_o,
  output logic [DATA_WIDTH-1:0] sum_o
);
  logic sa, sb;
  logic [DATA_WIDTH-1:0] b_eff;

  assign sa = operand_a_i[DATA_WIDTH-1];
  assign sb = operand_b_i[DATA_WIDTH-1];
  assign mag_a_o = sa ? (~operand_a_i + 1'b1) : operand_a_i;
  assign mag_b_o = sb ? (~operand_b_i + 1'b1) : operand_b_i;

  always_comb begin
    ctl_o.op  = cia_pkg::op_e'(req_type_i);
    ctl_o.neg = sa ^ sb;
    ctl_o.ovf = 1'b0;
    b_eff = (ctl_o.op == cia_pkg::OP_SUB) ? (~operand_b_i + 1'b1) : operand_b_i;
    sum_o = operand_a_i + b_eff;
    case (ctl_o.op)
      cia_pkg::OP_ADD: ctl_o.ovf = (sa == sb) && (sum_o[DATA_WIDTH-1] != sa);
      cia_pkg::OP_SUB: ctl_o.ovf = (sa != sb) && (sum_o[DATA_WIDTH-1] != sa);
      default:         ctl_o.ovf = 1'b0;
    endcase
  end
endmodule

// ----- hw/rtl/cia_cell.sv -----
`timescale 1ns / 1ps
module cia_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  cia_pkg::ctl_t           ctl_i,
  input  logic [DATA_WIDTH-1:0]   mag_a_i,
  input  logic [DATA_WIDTH-1:0]   mag_b_i,
  input  logic [DATA_WIDTH-1:0]   sum_i,
  input  logic [2*DATA_WIDTH-1:0] acc_i,
  input  logic [DATA_WIDTH-1:0]   rem_i,
  input  logic [DATA_WIDTH-1:0]   quo_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output cia_pkg::ctl_t           ctl_o,
  output logic [DATA_WIDTH-1:0]   mag_a_o,
  output logic [DATA_WIDTH-1:0]   mag_b_o,
  output logic [DATA_WIDTH-1:0]   sum_o,
  output logic [2*DATA_WIDTH-1:0] acc_o,
  output logic [DATA_WIDTH-1:0]   rem_o,
  output logic [DATA_WIDTH-1:0]   quo_o
);
  logic                    valid_q;
  cia_pkg::ctl_t           ctl_q;
  logic [DATA_WIDTH-1:0]   mag_a_q, mag_b_q, sum_q, rem_q, rem_d, quo_q;
  logic [2*DATA_WIDTH-1:0] acc_q, acc_d, addend;
  logic [DATA_WIDTH:0]     trial, diff;
  logic                    ge;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    addend = {{DATA_WIDTH{1'b0}}, mag_a_i} << IDX;
    acc_d  = mag_b_i[IDX] ? (acc_i + addend) : acc_i;
    trial  = {rem_i, mag_a_i[DATA_WIDTH-1-IDX]};
    diff   = trial - {1'b0, mag_b_i};
    ge     = !diff[DATA_WIDTH];
    rem_d  = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_q   <= ctl_i;
      mag_a_q <= mag_a_i;
      mag_b_q <= mag_b_i;
      sum_q   <= sum_i;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      quo_q   <= {quo_i[DATA_WIDTH-2:0], ge};
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign mag_a_o = mag_a_q;
  assign mag_b_o = mag_b_q;
  assign sum_o   = sum_q;
  assign acc_o   = acc_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
endmodule

// ----- hw/rtl/cia_back.sv -----
`timescale 1ns / 1ps
module cia_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  cia_pkg::ctl_t           ctl_i,
  input  logic [DATA_WIDTH-1:0]   mag_b_i,
  input  logic [DATA_WIDTH-1:0]   sum_i,
  input  logic [2*DATA_WIDTH-1:0] acc_i,
  input  logic [DATA_WIDTH-1:0]   quo_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [DATA_WIDTH-1:0]   value_o,
  output logic                    error_o
);
  localparam logic [DATA_WIDTH-1:0] SignBit = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                  valid_q, err_q, err_d;
  logic [DATA_WIDTH-1:0] val_q, val_d, mag, limit;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    limit = ctl_i.neg ? SignBit : (SignBit - 1'b1);
    mag   = quo_i;
    err_d = 1'b0;
    case (ctl_i.op)
      cia_pkg::OP_MUL: begin
        mag   = acc_i[DATA_WIDTH-1:0];
        err_d = (|acc_i[2*DATA_WIDTH-1:DATA_WIDTH]) || (mag > limit);
      end
      cia_pkg::OP_DIV: err_d = (mag_b_i == '0) || (quo_i > limit);
      default:         err_d = ctl_i.ovf;
    endcase
    if (ctl_i.op inside {cia_pkg::OP_ADD, cia_pkg::OP_SUB}) begin
      val_d = sum_i;
    end else begin
      val_d = ctl_i.neg ? (~mag + 1'b1) : mag;
    end
    if (err_d) begin
      val_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      val_q <= val_d;
      err_q <= err_d;
    end
  end

  assign valid_o = valid_q;
  assign value_o = val_q;
  assign error_o = err_q;
endmodule

// ----- hw/rtl/checked_integer_alu_unit.sv -----
`timescale 1ns / 1ps
// Overflow-checked signed integer ALU: add, subtract, multiply, divide.
// req_i carries req_type, operand_a and operand_b; rsp_o returns
// result_value and error_flag, one response per request, in order.
// A transfer happens on each edge with valid and ready both high.
// Overflow, divide by zero and minimum over minus one give value 0 with
// error_flag set.
// The datapath is a row of DATA_WIDTH cells; each cell adds one partial
// product of the multiply and resolves one quotient bit of the divide.
// An output register follows the row, giving DATA_WIDTH + 1 register stages.
// Throughput: one request per cycle while the receiver is not stalled, set by the one-step-per-cell row.
// Each cell holds while the one after it is full and stalled, so a stalled
// receiver backs the row up stage by stage; empty cells keep accepting.
// Reset clears all valid flags; no item is in flight afterwards.
module checked_integer_alu_unit #(
  parameter int DATA_WIDTH = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  cia_req_if.sink   req_i,
  cia_rsp_if.source rsp_o
);
  localparam int W = DATA_WIDTH;

  logic                valid_c [W+1];
  logic                ready_c [W+1];
  cia_pkg::ctl_t       ctl_c   [W+1];
  logic [W-1:0]        mag_a_c [W+1];
  logic [W-1:0]        mag_b_c [W+1];
  logic [W-1:0]        sum_c   [W+1];
  logic [2*W-1:0]      acc_c   [W+1];
  logic [W-1:0]        rem_c   [W+1];
  logic [W-1:0]        quo_c   [W+1];
  logic [W-1:0]        value;

  cia_front #(.DATA_WIDTH(W)) u_front (
    .req_type_i (req_i.req_type),
    .operand_a_i(req_i.operand_a),
    .operand_b_i(req_i.operand_b),
    .ctl_o      (ctl_c[0]),
    .mag_a_o    (mag_a_c[0]),
    .mag_b_o    (mag_b_c[0]),
    .sum_o      (sum_c[0])
  );

  assign valid_c[0]  = req_i.valid;
  assign req_i.ready = ready_c[0];
  assign acc_c[0]    = '0;
  assign rem_c[0]    = '0;
  assign quo_c[0]    = '0;

  for (genvar k = 0; k < W; k++) begin : g_cell
    cia_cell #(.DATA_WIDTH(W), .IDX(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_c[k]),
      .ready_o(ready_c[k]),
      .ctl_i  (ctl_c[k]),
      .mag_a_i(mag_a_c[k]),
      .mag_b_i(mag_b_c[k]),
      .sum_i  (sum_c[k]),
      .acc_i  (acc_c[k]),
      .rem_i  (rem_c[k]),
      .quo_i  (quo_c[k]),
      .valid_o(valid_c[k+1]),
      .ready_i(ready_c[k+1]),
      .ctl_o  (ctl_c[k+1]),
      .mag_a_o(mag_a_c[k+1]),
      .mag_b_o(mag_b_c[k+1]),
      .sum_o  (sum_c[k+1]),
      .acc_o  (acc_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .quo_o  (quo_c[k+1])
    );
  end

  cia_back #(.DATA_WIDTH(W)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_c[W]),
    .ready_o(ready_c[W]),
    .ctl_i  (ctl_c[W]),
    .mag_b_i(mag_b_c[W]),
    .sum_i  (sum_c[W]),
    .acc_i  (acc_c[W]),
    .quo_i  (quo_c[W]),
    .valid_o(rsp_o.valid),
    .ready_i(rsp_o.ready),
    .value_o(value),
    .error_o(rsp_o.error_flag)
  );

  assign rsp_o.result_value = value;
endmodule
